// File: rtl/rwd_pkg.sv
// ----------------------------------------------------------------------------
// rwd_pkg: shared definitions for the readout word decoder
// word keys, decoded operation codes and the record layout
// ----------------------------------------------------------------------------
`default_nettype none

package rwd_pkg;

  // default configuration of the chip context and count table
  localparam int DEF_NUM_CHIPS    = 8;
  localparam int DEF_NUM_CHANNELS = 64;

  // queue depths between the parts
  localparam int OPQ_DEPTH = 2;
  localparam int OQ_DEPTH  = 4;

  // word keys in bits 63:59
  localparam logic [4:0] KEY_EVENT = 5'h0;
  localparam logic [4:0] KEY_FRAME = 5'h4;
  localparam logic [4:0] KEY_COUNT = 5'h8;

  typedef logic [1:0] op_kind_t;

  localparam op_kind_t OP_EVENT = 2'd0;
  localparam op_kind_t OP_FRAME = 2'd1;
  localparam op_kind_t OP_COUNT = 2'd2;

  // decoded word handed from the front to the back
  typedef struct packed {
    op_kind_t    kind;
    logic [2:0]  chip;
    logic [5:0]  channel;
    logic        chan_ok;
    logic [47:0] data;
  } op_t;

  // one event record
  typedef struct packed {
    logic [2:0]  chip;
    logic [5:0]  channel;
    logic [1:0]  tac;
    logic [15:0] time_coarse;
    logic [9:0]  energy_coarse;
    logic [9:0]  time_fine;
    logic [9:0]  energy_fine;
    logic [15:0] frame_number;
    logic [14:0] upset_count;
    logic [31:0] rollovers;
    logic [23:0] counter_value;
    logic [7:0]  board;
  } rec_t;

endpackage

`default_nettype wire

// File: rtl/rwd_ram.sv
// ----------------------------------------------------------------------------
// rwd_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rwd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/rwd_front.sv
// ----------------------------------------------------------------------------
// rwd_front: word intake and classification
// decodes the key, filters words that do nothing, queues decoded words
// ----------------------------------------------------------------------------
`default_nettype none

module rwd_front import rwd_pkg::*; #(
  parameter int NUM_CHIPS    = DEF_NUM_CHIPS,
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic [63:0] frame_word,
  input  wire logic        hold,
  output logic             full,
  output logic             op_valid,
  output op_t              op,
  input  wire logic        op_pop
);

  localparam int PW = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int CW = $clog2(OPQ_DEPTH + 1);

  op_t           op_q [OPQ_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic [4:0] key;
  logic [2:0] chip;
  logic       chip_ok;
  logic       cnt_ch_ok;
  logic       evt_ch_ok;
  logic       keep;
  op_t        new_op;
  logic       wr_en;

  always_comb begin
    key       = frame_word[63:59];
    chip      = frame_word[58:56];
    chip_ok   = {1'b0, chip} < 4'(NUM_CHIPS);
    cnt_ch_ok = {1'b0, frame_word[29:24]} < 7'(NUM_CHANNELS);
    evt_ch_ok = {1'b0, frame_word[53:48]} < 7'(NUM_CHANNELS);

    new_op.kind    = OP_EVENT;
    new_op.chip    = chip;
    new_op.channel = frame_word[53:48];
    new_op.chan_ok = evt_ch_ok;
    new_op.data    = frame_word[47:0];
    keep           = 1'b0;

    unique case (key)
      KEY_FRAME: begin
        new_op.kind = OP_FRAME;
        keep        = chip_ok;
      end
      KEY_COUNT: begin
        new_op.kind    = OP_COUNT;
        new_op.channel = frame_word[29:24];
        new_op.chan_ok = cnt_ch_ok;
        keep           = chip_ok && cnt_ch_ok;
      end
      KEY_EVENT: begin
        keep = chip_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full     = (count == CW'(OPQ_DEPTH)) || hold;
  assign wr_en    = push && !full && keep;
  assign op_valid = (count != '0);
  assign op       = op_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      op_q[wr_ptr] <= new_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(OPQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (op_pop) begin
        rd_ptr <= (rd_ptr == PW'(OPQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(wr_en) - CW'(op_pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/rwd_back.sv
// ----------------------------------------------------------------------------
// rwd_back: execution of decoded words
// chip context, count table with clearing pass, record queue
// ----------------------------------------------------------------------------
`default_nettype none

module rwd_back import rwd_pkg::*; #(
  parameter int NUM_CHIPS    = DEF_NUM_CHIPS,
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       op_valid,
  input  wire op_t        op,
  output logic            op_pop,
  input  wire logic [7:0] board_id,
  output logic            busy,
  output logic            empty,
  input  wire logic       pop,
  output rec_t            rec
);

  localparam int DEPTH = NUM_CHIPS * NUM_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
  localparam int QPW   = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int QCW   = $clog2(OQ_DEPTH + 1);

  // chip context
  logic        seen        [NUM_CHIPS];
  logic [15:0] last_frame  [NUM_CHIPS];
  logic [14:0] last_upsets [NUM_CHIPS];
  logic [31:0] wrap_count  [NUM_CHIPS];

  // count table clearing
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // read stage
  logic s1_valid;
  logic s1_chan_ok;
  rec_t s1_rec;

  // record queue
  rec_t           oq [OQ_DEPTH];
  logic [QPW-1:0] oq_wr;
  logic [QPW-1:0] oq_rd;
  logic [QCW-1:0] oq_count;

  logic          room;
  logic          issue;
  logic [IW-1:0] idx;
  logic [15:0]   fc;
  logic [14:0]   seu;
  logic [AW-1:0] op_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [23:0]   ram_wdata;
  logic [23:0]   ram_rdata;
  logic          oq_pop;
  rec_t          push_rec;
  logic          s1_valid_next;
  logic          frame_we;
  logic          wrap_inc;

  assign room  = ((QCW + 1)'(oq_count) + (QCW + 1)'(s1_valid)) < (QCW + 1)'(OQ_DEPTH);
  assign issue = op_valid && !clearing && room;
  assign op_pop = issue;
  assign busy   = clearing;

  assign idx = op.chip[IW-1:0];
  assign fc  = op.data[30:15];
  assign seu = op.data[14:0];
  assign op_addr = AW'(AW'(op.chip) * AW'(NUM_CHANNELS) + AW'(op.channel));

  always_comb begin
    frame_we      = 1'b0;
    s1_valid_next = 1'b0;
    ram_we        = clearing;
    unique case (op.kind)
      OP_FRAME: frame_we = issue;
      OP_COUNT: ram_we   = clearing || issue;
      OP_EVENT: s1_valid_next = issue && seen[idx];
      default: begin
        frame_we = 1'b0;
      end
    endcase
  end

  assign wrap_inc  = seen[idx] && (fc < last_frame[idx]) && (wrap_count[idx] != '1);
  assign ram_waddr = clearing ? clr_addr : op_addr;
  assign ram_wdata = clearing ? '0 : op.data[23:0];

  rwd_ram #(
    .WIDTH (24),
    .DEPTH (DEPTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (op_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      for (int i = 0; i < NUM_CHIPS; i++) begin
        seen[i]        <= 1'b0;
        last_frame[i]  <= '0;
        last_upsets[i] <= '0;
        wrap_count[i]  <= '0;
      end
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (frame_we) begin
        seen[idx]        <= 1'b1;
        last_frame[idx]  <= fc;
        last_upsets[idx] <= seu;
        if (wrap_inc) begin
          wrap_count[idx] <= wrap_count[idx] + 32'd1;
        end
      end
    end
  end

  // event context is captured at issue, the count follows from the ram
  always_ff @(posedge clk) begin
    s1_chan_ok           <= op.chan_ok;
    s1_rec.chip          <= op.chip;
    s1_rec.channel       <= op.channel;
    s1_rec.tac           <= op.data[47:46];
    s1_rec.time_coarse   <= op.data[45:30];
    s1_rec.energy_coarse <= op.data[29:20];
    s1_rec.time_fine     <= op.data[19:10];
    s1_rec.energy_fine   <= op.data[9:0];
    s1_rec.frame_number  <= last_frame[idx];
    s1_rec.upset_count   <= last_upsets[idx];
    s1_rec.rollovers     <= wrap_count[idx];
    s1_rec.counter_value <= '0;
    s1_rec.board         <= board_id;
  end

  always_comb begin
    push_rec = s1_rec;
    push_rec.counter_value = s1_chan_ok ? ram_rdata : '0;
  end

  assign empty  = (oq_count == '0);
  assign oq_pop = pop && !empty;
  assign rec    = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      oq[oq_wr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      s1_valid <= s1_valid_next;
      if (s1_valid) begin
        oq_wr <= (oq_wr == QPW'(OQ_DEPTH - 1)) ? '0 : oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= (oq_rd == QPW'(OQ_DEPTH - 1)) ? '0 : oq_rd + 1'b1;
      end
      oq_count <= oq_count + QCW'(s1_valid) - QCW'(oq_pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/readout_word_decoder.sv
// ----------------------------------------------------------------------------
// readout_word_decoder: readout word classifier and event record builder
// takes 64-bit readout words and emits one record per valid event word
// ----------------------------------------------------------------------------
// The decoder takes one 64-bit word per clock while full is low and keys on
// bits 63:59: frame words update a chip's frame count, upset count and
// rollover counter, count words update a 24-bit counter per chip and channel,
// and event words from a chip that has sent a frame word yield one record
// joining the hit fields with that chip's context and board_id; all other
// words are dropped. Sustained rate is one word per cycle while the record
// queue has room, set by the back part, which executes one decoded word per
// cycle against the chip context and the simple dual-port count table ram.
// An event record passes the front queue, the read stage and the record queue
// before it is visible (empty low). After reset the count table is zeroed by
// a clearing pass over all NUM_CHIPS * NUM_CHANNELS entries (512 at the
// defaults) during which full stays high; board_id writes are taken anyway.
// ----------------------------------------------------------------------------
`default_nettype none

module readout_word_decoder import rwd_pkg::*; #(
  parameter int NUM_CHIPS    = DEF_NUM_CHIPS,
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // word input queue side
  input  wire logic        push,
  input  wire logic [63:0] frame_word,
  output logic             full,
  // record output queue side
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       chip,
  output logic [5:0]       channel,
  output logic [1:0]       tac,
  output logic [15:0]      time_coarse,
  output logic [9:0]       energy_coarse,
  output logic [9:0]       time_fine,
  output logic [9:0]       energy_fine,
  output logic [15:0]      frame_number,
  output logic [14:0]      upset_count,
  output logic [31:0]      rollovers,
  output logic [23:0]      counter_value,
  output logic [7:0]       board,
  // configuration
  input  wire logic        board_id_we,
  input  wire logic [7:0]  board_id
);

  // board id register
  logic [7:0] board_reg;

  // front to back handoff
  logic op_valid;
  op_t  op;
  logic op_pop;

  // back part busy with the clearing pass
  logic back_busy;

  // head record of the output queue
  rec_t rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_reg <= '0;
    end else if (board_id_we) begin
      board_reg <= board_id;
    end
  end

  // front: key decode and filtering, small queue of decoded words
  rwd_front #(
    .NUM_CHIPS    (NUM_CHIPS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .frame_word (frame_word),
    .hold       (back_busy),
    .full       (full),
    .op_valid   (op_valid),
    .op         (op),
    .op_pop     (op_pop)
  );

  // back: context update, count table, record queue
  rwd_back #(
    .NUM_CHIPS    (NUM_CHIPS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .board_id (board_reg),
    .busy     (back_busy),
    .empty    (empty),
    .pop      (pop),
    .rec      (rec)
  );

  // record fields onto the result ports
  assign chip          = rec.chip;
  assign channel       = rec.channel;
  assign tac           = rec.tac;
  assign time_coarse   = rec.time_coarse;
  assign energy_coarse = rec.energy_coarse;
  assign time_fine     = rec.time_fine;
  assign energy_fine   = rec.energy_fine;
  assign frame_number  = rec.frame_number;
  assign upset_count   = rec.upset_count;
  assign rollovers     = rec.rollovers;
  assign counter_value = rec.counter_value;
  assign board         = rec.board;

`ifndef SYNTHESIS
  // no word may enter while the count table is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    back_busy |-> full)
    else $error("word input open during count table clearing");

  // the back part only takes a decoded word that the front offers
  a_pop_needs_valid: assert property (@(posedge clk) disable iff (rst)
    op_pop |-> op_valid)
    else $error("back part took a word from an empty front queue");

  // reset leaves no record and starts the clearing pass
  a_reset_state: assert property (@(posedge clk)
    rst |=> (empty && full))
    else $error("decoder not empty and blocked after reset");
`endif

endmodule

`default_nettype wire
